FILE: hw/rtl/pwbd_pkg.sv
// ----------------------------------------------------------------------------
// pwbd_pkg
// Shared types and constants of the parity woven block deframer: item
// layouts, status codes, register indexes and the chain-word constants.
// ----------------------------------------------------------------------------
package pwbd_pkg;

    // Result status codes.
    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_TRUNCATED = 3'd1,
        STATUS_XOR_BAD   = 3'd2,
        STATUS_CHAIN_BAD = 3'd3,
        STATUS_ORDER_BAD = 3'd4
    } status_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_SECTION_LENGTH = 2'd0,
        REG_ENCODED        = 2'd1,
        REG_OBFUSCATED     = 2'd2
    } reg_index_t;

    // One input item.
    typedef struct packed {
        logic       first_byte;
        logic [7:0] in_byte;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic        has_data;
        logic [7:0]  out_byte;
        status_t     status;
        logic [31:0] block_number;
        logic        run_last;
    } out_item_t;

    // Request from the ingest logic to the release sequencer.
    typedef struct packed {
        logic      single;   // one result item, carried in item
        logic      run;      // release the buffered block
        out_item_t item;
    } pwbd_req_t;

    localparam logic [7:0]  OBF_KEY      = 8'h4D;
    localparam int          TRAILER_LEN  = 12;
    localparam logic [3:0]  LAST_TRAILER = 4'd11;
    localparam logic [31:0] SEED_WORD    = 32'hA7C3E91F;
    localparam logic [31:0] FNV_PRIME    = 32'h01000193;

    // The chain step folds x in and out again, so it reduces to a multiply
    // of the chain word by the fourth power of the prime.
    localparam logic [63:0] FNV_P2_FULL = 64'(FNV_PRIME) * 64'(FNV_PRIME);
    localparam logic [31:0] FNV_P2      = FNV_P2_FULL[31:0];
    localparam logic [63:0] FNV_P4_FULL = 64'(FNV_P2) * 64'(FNV_P2);
    localparam logic [31:0] CHAIN_STEP  = FNV_P4_FULL[31:0];
    localparam logic [63:0] CHAIN_INIT_FULL = 64'(SEED_WORD) * 64'(CHAIN_STEP);
    localparam logic [31:0] CHAIN_INIT  = CHAIN_INIT_FULL[31:0];

endpackage

FILE: hw/rtl/parity_woven_block_deframer_unit.sv
// ----------------------------------------------------------------------------
// parity_woven_block_deframer_unit
// Section deframer: strips and checks block trailers, buffers each block in
// a RAM and releases its data bytes once the trailer has passed.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-------------------------------
//  in      | input     | in_valid / in_stall   | in_item  (first_byte, in_byte)
//  out     | output    | out_valid / out_stall | out_item (has_data .. run_last)
//  cfg     | input     | cfg_write             | cfg_index, cfg_data
//
//  An input item is taken when the release sequencer is idle and the output
//  register is free or being emptied. A block that passes its trailer check
//  is read back from the store through its single read port: the first read
//  is started, then one data byte follows per cycle while the output is not
//  stalled. Input is stalled for as long as the release runs, which keeps the
//  store from being written while it is read. Reset clears all control state;
//  the store itself is not cleared and needs no clearing pass.
//
module parity_woven_block_deframer_unit #(
    parameter int STRIDE      = 64,
    parameter int LENGTH_BITS = 29
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  pwbd_pkg::in_item_t     in_item,
    output logic                   out_valid,
    input  logic                   out_stall,
    output pwbd_pkg::out_item_t    out_item,
    input  logic                   cfg_write,
    input  logic [1:0]             cfg_index,
    input  logic [LENGTH_BITS-1:0] cfg_data
);
    import pwbd_pkg::*;

    localparam int FILL_W = $clog2(STRIDE + 1);
    localparam int ADDR_W = (STRIDE > 1) ? $clog2(STRIDE) : 1;

    logic [LENGTH_BITS-1:0] section_length_reg;
    logic                   encoded_reg;
    logic                   obfuscated_reg;

    logic              accept;
    logic              rel_ready;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    pwbd_req_t         req;
    logic [FILL_W-1:0] fill;

    assign in_stall = !rel_ready;
    assign accept   = in_valid && rel_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_length_reg <= '0;
            encoded_reg        <= 1'b1;
            obfuscated_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SECTION_LENGTH: section_length_reg <= cfg_data;
                REG_ENCODED:        encoded_reg        <= cfg_data[0];
                REG_OBFUSCATED:     obfuscated_reg     <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Block store.
    pwbd_ram #(
        .WIDTH (8),
        .DEPTH (STRIDE)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Byte intake and trailer checks.
    pwbd_ingest #(
        .STRIDE      (STRIDE),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_ingest (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .in_item        (in_item),
        .section_length (section_length_reg),
        .encoded        (encoded_reg),
        .obfuscated     (obfuscated_reg),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .req            (req),
        .fill           (fill)
    );

    // Release sequencer and output register.
    pwbd_release #(
        .STRIDE (STRIDE)
    ) u_release (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .run_count (fill),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .ready     (rel_ready)
    );

    // A full output register that is held back must hold back the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while the output register is full and stalled");

    // Results without a data byte always close the item's results.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.has_data |-> out_item.run_last)
        else $error("status-only result not marked as last");

    // Released data never carries a failure code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.has_data |-> out_item.status == STATUS_OK)
        else $error("data byte released with a failure status");

    // The store is never written while a block is being read out.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !wr_en)
        else $error("store written during a release");

endmodule

FILE: hw/rtl/pwbd_ram.sv
// ----------------------------------------------------------------------------
// pwbd_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module pwbd_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/pwbd_ingest.sv
// ----------------------------------------------------------------------------
// pwbd_ingest
// Per-byte section state: position, de-obfuscation, block buffering into the
// store, trailer collection and the three trailer checks.
// ----------------------------------------------------------------------------
module pwbd_ingest #(
    parameter  int STRIDE      = 64,
    parameter  int LENGTH_BITS = 29,
    localparam int FILL_W      = $clog2(STRIDE + 1),
    localparam int ADDR_W      = (STRIDE > 1) ? $clog2(STRIDE) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  pwbd_pkg::in_item_t   in_item,
    input  logic [LENGTH_BITS-1:0] section_length,
    input  logic                 encoded,
    input  logic                 obfuscated,
    output logic                 wr_en,
    output logic [ADDR_W-1:0]    wr_addr,
    output logic [7:0]           wr_data,
    output pwbd_pkg::pwbd_req_t  req,
    output logic [FILL_W-1:0]    fill
);
    import pwbd_pkg::*;

    logic [LENGTH_BITS-1:0] pos_reg, pos_next, pos_e;
    logic [FILL_W-1:0]      fill_reg, fill_next, fill_e;
    logic [3:0]             tcount_reg, tcount_next, tcount_e;
    logic [95:0]            tbytes_reg, tbytes_next;
    logic [7:0]             xor_reg, xor_next, xor_e;
    logic [31:0]            expect_reg, expect_next, expect_e;
    logic [31:0]            counter_reg, counter_next, counter_e;
    logic                   failed_reg, failed_next, failed_e;

    logic                   first;
    logic [7:0]             byte_dec;
    logic                   room_ok;
    logic [31:0]            word_xor, word_chain, word_index;

    assign first = in_item.first_byte;

    // State as seen by this item: a first byte starts from the cleared values.
    assign pos_e     = first ? '0 : pos_reg;
    assign fill_e    = first ? '0 : fill_reg;
    assign tcount_e  = first ? '0 : tcount_reg;
    assign xor_e     = first ? '0 : xor_reg;
    assign expect_e  = first ? CHAIN_INIT : expect_reg;
    assign counter_e = first ? '0 : counter_reg;
    assign failed_e  = first ? 1'b0 : failed_reg;

    // Position-keyed de-obfuscation.
    assign byte_dec = obfuscated ? (in_item.in_byte ^ OBF_KEY ^ pos_e[7:0]) : in_item.in_byte;

    // At least a trailer's worth of the section remains after this byte.
    assign room_ok = ({1'b0, pos_e} + (LENGTH_BITS + 1)'(TRAILER_LEN)) < {1'b0, section_length};

    // Trailer words; the last byte arrives with the current item.
    assign word_xor   = tbytes_reg[31:0];
    assign word_chain = tbytes_reg[63:32];
    assign word_index = {in_item.in_byte ^ (obfuscated ? (OBF_KEY ^ pos_e[7:0]) : 8'h00),
                         tbytes_reg[87:64]};

    assign wr_addr = fill_e[ADDR_W-1:0];
    assign wr_data = byte_dec;
    assign fill    = fill_e;

    // Byte handling and trailer checks.
    always_comb
    begin
        pos_next     = pos_reg;
        fill_next    = fill_reg;
        tcount_next  = tcount_reg;
        tbytes_next  = tbytes_reg;
        xor_next     = xor_reg;
        expect_next  = expect_reg;
        counter_next = counter_reg;
        failed_next  = failed_reg;
        wr_en        = 1'b0;
        req          = '0;
        if (accept)
        begin
            pos_next     = pos_e;
            fill_next    = fill_e;
            tcount_next  = tcount_e;
            xor_next     = xor_e;
            expect_next  = expect_e;
            counter_next = counter_e;
            failed_next  = failed_e;
            if (!failed_e && (pos_e < section_length))
            begin
                pos_next = pos_e + 1'b1;
                priority if (!encoded)
                begin
                    // Raw section: the byte goes straight out.
                    req.single = 1'b1;
                    req.item   = '{has_data: 1'b1, out_byte: in_item.in_byte,
                                   status: STATUS_OK, block_number: 32'd0, run_last: 1'b1};
                end
                else if ((tcount_e == 4'd0) && (fill_e == '0) && !room_ok)
                begin
                    // A block starts with no room left for data and trailer.
                    failed_next = 1'b1;
                    req.single  = 1'b1;
                    req.item    = '{has_data: 1'b0, out_byte: 8'h00,
                                    status: STATUS_TRUNCATED, block_number: counter_e,
                                    run_last: 1'b1};
                end
                else if ((tcount_e == 4'd0) && (fill_e < FILL_W'(STRIDE)) && room_ok)
                begin
                    // Data byte: buffer it and fold it into the XOR.
                    wr_en     = 1'b1;
                    fill_next = fill_e + 1'b1;
                    xor_next  = xor_e ^ byte_dec;
                end
                else if (tcount_e != LAST_TRAILER)
                begin
                    // Trailer byte other than the last one.
                    tbytes_next[{tcount_e, 3'b000} +: 8] = byte_dec;
                    tcount_next = tcount_e + 1'b1;
                end
                else
                begin
                    // Last trailer byte: run the checks in order.
                    tbytes_next[{tcount_e, 3'b000} +: 8] = byte_dec;
                    tcount_next = 4'd0;
                    req.item    = '{has_data: 1'b0, out_byte: 8'h00, status: STATUS_OK,
                                    block_number: counter_e, run_last: 1'b1};
                    priority if (word_xor != {24'h000000, xor_e})
                    begin
                        failed_next     = 1'b1;
                        req.single      = 1'b1;
                        req.item.status = STATUS_XOR_BAD;
                    end
                    else if (word_chain != expect_e)
                    begin
                        failed_next     = 1'b1;
                        req.single      = 1'b1;
                        req.item.status = STATUS_CHAIN_BAD;
                    end
                    else if (word_index != counter_e)
                    begin
                        failed_next     = 1'b1;
                        req.single      = 1'b1;
                        req.item.status = STATUS_ORDER_BAD;
                    end
                    else
                    begin
                        // Block good: release what was buffered, advance the chain.
                        expect_next  = expect_e * CHAIN_STEP;
                        counter_next = counter_e + 32'd1;
                        xor_next     = 8'h00;
                        fill_next    = '0;
                        if (fill_e == '0)
                        begin
                            req.single = 1'b1;
                        end
                        else
                        begin
                            req.run = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // Running state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            fill_reg    <= '0;
            tcount_reg  <= 4'd0;
            tbytes_reg  <= '0;
            xor_reg     <= 8'h00;
            expect_reg  <= CHAIN_INIT;
            counter_reg <= 32'd0;
            failed_reg  <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            fill_reg    <= fill_next;
            tcount_reg  <= tcount_next;
            tbytes_reg  <= tbytes_next;
            xor_reg     <= xor_next;
            expect_reg  <= expect_next;
            counter_reg <= counter_next;
            failed_reg  <= failed_next;
        end
    end

endmodule

FILE: hw/rtl/pwbd_release.sv
// ----------------------------------------------------------------------------
// pwbd_release
// Release sequencer and output register: reads a checked block out of the store
// one byte a cycle unless the output stalls, and presents single result items.
// ----------------------------------------------------------------------------
module pwbd_release #(
    parameter  int STRIDE = 64,
    localparam int FILL_W = $clog2(STRIDE + 1),
    localparam int ADDR_W = (STRIDE > 1) ? $clog2(STRIDE) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pwbd_pkg::pwbd_req_t  req,
    input  logic [FILL_W-1:0]    run_count,
    output logic                 rd_en,
    output logic [ADDR_W-1:0]    rd_addr,
    input  logic [7:0]           rd_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output pwbd_pkg::out_item_t  out_item,
    output logic                 ready
);
    import pwbd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SHOW = 3'b100
    } rel_state_t;

    rel_state_t        state_reg, state_next;
    logic [FILL_W-1:0] count_reg, count_next;
    logic [FILL_W-1:0] idx_reg, idx_next;
    logic [31:0]       blk_reg, blk_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;
    logic              can_load;
    logic              is_last;

    assign can_load  = !out_valid_reg || !out_stall;
    assign is_last   = (idx_reg + 1'b1) == count_reg;
    assign ready     = (state_reg == S_IDLE) && can_load;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Sequencer: one read in flight, the read data holds while the output waits.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        blk_next       = blk_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_item_next  = out_item_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[ADDR_W-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.single)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = req.item;
                end
                if (req.run)
                begin
                    count_next = run_count;
                    blk_next   = req.item.block_number;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                idx_next   = '0;
                state_next = S_SHOW;
            end
            S_SHOW:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '{has_data: 1'b1, out_byte: rd_data, status: STATUS_OK,
                                       block_number: blk_reg, run_last: is_last};
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg[ADDR_W-1:0] + 1'b1;
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        count_reg    <= count_next;
        idx_reg      <= idx_next;
        blk_reg      <= blk_next;
        out_item_reg <= out_item_next;
    end

endmodule
